@@ design/nrm_pkg.sv @@
// Shared widths and constants for the vector normalize core.
package nrm_pkg;
  localparam int DATA_W = 32;   // width of every field on the channels
  localparam int FRAC_W = 30;   // fraction bits of a unit component
  localparam int QUOT_W = 31;   // quotient bits, unit magnitude is at most 2^30
  localparam int LANES  = 3;
endpackage

@@ design/nrm_if.sv @@
// Request channels: input vector and normalized result.
interface nrm_in_if;
  import nrm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] vec_x;
  logic signed [DATA_W-1:0] vec_y;
  logic signed [DATA_W-1:0] vec_z;
  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface nrm_out_if;
  import nrm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [DATA_W-1:0] vec_length;
  logic signed [DATA_W-1:0] unit_x;
  logic signed [DATA_W-1:0] unit_y;
  logic signed [DATA_W-1:0] unit_z;
  modport source (output valid, vec_length, unit_x, unit_y, unit_z, input ready);
  modport sink (input valid, vec_length, unit_x, unit_y, unit_z, output ready);
endinterface

@@ design/nrm_sqrt_cell.sv @@
// One square root cell: retires one root bit per request per cycle while en is high.
module nrm_sqrt_cell #(
  parameter int W = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           valid_i,
  input  logic [2*W-1:0]                 rad_i,
  input  logic [W+2:0]                   rem_i,
  input  logic [W-1:0]                   root_i,
  input  logic [nrm_pkg::LANES-1:0][W-1:0] mag_i,
  input  logic [nrm_pkg::LANES-1:0]      neg_i,
  output logic                           valid_o,
  output logic [2*W-1:0]                 rad_o,
  output logic [W+2:0]                   rem_o,
  output logic [W-1:0]                   root_o,
  output logic [nrm_pkg::LANES-1:0][W-1:0] mag_o,
  output logic [nrm_pkg::LANES-1:0]      neg_o
);
  import nrm_pkg::*;

  logic                      valid_r;
  logic [2*W-1:0]            rad_r;
  logic [W+2:0]              rem_r;
  logic [W-1:0]              root_r;
  logic [LANES-1:0][W-1:0]   mag_r;
  logic [LANES-1:0]          neg_r;
  logic [W+2:0]              rem_sh;
  logic [W+2:0]              trial;
  logic                      ge;

  // remainder stays below 2^(W+1), so its low bits carry it whole
  assign rem_sh = {rem_i[W:0], rad_i[2*W-1 -: 2]};
  assign trial  = {1'b0, root_i, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[2*W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_i[W-2:0], ge};
      mag_r  <= mag_i;
      neg_r  <= neg_i;
    end
  end

  assign valid_o = valid_r;
  assign rad_o   = rad_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign mag_o   = mag_r;
  assign neg_o   = neg_r;
endmodule

@@ design/nrm_div_cell.sv @@
// One divider cell: retires one quotient bit in each of the three lanes.
module nrm_div_cell #(
  parameter int W = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   valid_i,
  input  logic [W-1:0]                           len_i,
  input  logic [nrm_pkg::LANES-1:0][W-1:0]       rem_i,
  input  logic [nrm_pkg::LANES-1:0]              nb_i,
  input  logic [nrm_pkg::LANES-1:0][nrm_pkg::QUOT_W-1:0] q_i,
  input  logic [nrm_pkg::LANES-1:0]              neg_i,
  output logic                                   valid_o,
  output logic [W-1:0]                           len_o,
  output logic [nrm_pkg::LANES-1:0][W-1:0]       rem_o,
  output logic [nrm_pkg::LANES-1:0]              nb_o,
  output logic [nrm_pkg::LANES-1:0][nrm_pkg::QUOT_W-1:0] q_o,
  output logic [nrm_pkg::LANES-1:0]              neg_o
);
  import nrm_pkg::*;

  logic                           valid_r;
  logic [W-1:0]                   len_r;
  logic [LANES-1:0][W-1:0]        rem_r;
  logic [LANES-1:0][QUOT_W-1:0]   q_r;
  logic [LANES-1:0]               neg_r;
  logic [LANES-1:0][W:0]          rs;
  logic [LANES-1:0]               ge;
  logic [LANES-1:0][W:0]          diff;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rs[k]   = {rem_i[k], nb_i[k]};
      ge[k]   = (rs[k] >= {1'b0, len_i});
      diff[k] = rs[k] - {1'b0, len_i};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_r <= len_i;
      neg_r <= neg_i;
      for (int k = 0; k < LANES; k++) begin
        rem_r[k] <= ge[k] ? diff[k][W-1:0] : rs[k][W-1:0];
        q_r[k]   <= {q_i[k][QUOT_W-2:0], ge[k]};
      end
    end
  end

  assign valid_o = valid_r;
  assign len_o   = len_r;
  assign rem_o   = rem_r;
  assign nb_o    = '0;  // dividend bits below the first are zero
  assign q_o     = q_r;
  assign neg_o   = neg_r;
endmodule

@@ design/vector_normalize_core.sv @@
// Top level: 3-D vector length and unit vector, fully pipelined.
// Takes one vector per cycle and returns one result per cycle while results are
// taken. A request passes through the magnitude, square and sum registers, one
// square root cell per root bit (COMPONENT_WIDTH cells), 31 divider cells for
// the Q1.30 quotients, and the output register. The whole pipe holds when a
// finished result is not taken.
module vector_normalize_core #(
  parameter int COMPONENT_WIDTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  nrm_in_if.sink    in_chan,
  nrm_out_if.source out_chan
);
  import nrm_pkg::*;

  localparam int W = COMPONENT_WIDTH;

  logic adv;

  logic [LANES-1:0][W-1:0]   raw;
  logic [LANES-1:0]          neg_in;
  logic [LANES-1:0][W-1:0]   mag_in;

  logic                      v0_r, v1_r, v2_r;
  logic [LANES-1:0][W-1:0]   mag0_r, mag1_r, mag2_r;
  logic [LANES-1:0]          neg0_r, neg1_r, neg2_r;
  logic [LANES-1:0][2*W-1:0] sq1_r;
  logic [2*W-1:0]            sum2_r;

  logic                      sv   [0:W];
  logic [2*W-1:0]            srad [0:W];
  logic [W+2:0]              srem [0:W];
  logic [W-1:0]              sroot[0:W];
  logic [LANES-1:0][W-1:0]   smag [0:W];
  logic [LANES-1:0]          sneg [0:W];

  logic                              dv   [0:QUOT_W];
  logic [W-1:0]                      dlen [0:QUOT_W];
  logic [LANES-1:0][W-1:0]           drem [0:QUOT_W];
  logic [LANES-1:0]                  dnb  [0:QUOT_W];
  logic [LANES-1:0][QUOT_W-1:0]      dq   [0:QUOT_W];
  logic [LANES-1:0]                  dneg [0:QUOT_W];

  logic                              out_valid_r;
  logic [DATA_W-1:0]                 len_out_r;
  logic [LANES-1:0][DATA_W-1:0]      unit_out_r;
  logic [LANES-1:0][DATA_W-1:0]      unit_nxt;
  logic [DATA_W-1:0]                 uq;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  assign raw[0] = in_chan.vec_x[W-1:0];
  assign raw[1] = in_chan.vec_y[W-1:0];
  assign raw[2] = in_chan.vec_z[W-1:0];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      neg_in[k] = raw[k][W-1];
      mag_in[k] = neg_in[k] ? (~raw[k] + 1'b1) : raw[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_chan.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag0_r <= mag_in;
      neg0_r <= neg_in;
      for (int k = 0; k < LANES; k++) begin
        sq1_r[k] <= (2*W)'(mag0_r[k]) * (2*W)'(mag0_r[k]);
      end
      mag1_r <= mag0_r;
      neg1_r <= neg0_r;
      sum2_r <= sq1_r[0] + sq1_r[1] + sq1_r[2];
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
    end
  end

  assign sv[0]    = v2_r;
  assign srad[0]  = sum2_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign smag[0]  = mag2_r;
  assign sneg[0]  = neg2_r;

  for (genvar i = 0; i < W; i++) begin : g_sqrt
    nrm_sqrt_cell #(.W(W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (sv[i]),
      .rad_i   (srad[i]),
      .rem_i   (srem[i]),
      .root_i  (sroot[i]),
      .mag_i   (smag[i]),
      .neg_i   (sneg[i]),
      .valid_o (sv[i+1]),
      .rad_o   (srad[i+1]),
      .rem_o   (srem[i+1]),
      .root_o  (sroot[i+1]),
      .mag_o   (smag[i+1]),
      .neg_o   (sneg[i+1])
    );
  end

  // quotient is below 2^31, so division starts from mag >> 1
  assign dv[0]   = sv[W];
  assign dlen[0] = sroot[W];
  assign dneg[0] = sneg[W];
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      drem[0][k] = {1'b0, smag[W][k][W-1:1]};
      dnb[0][k]  = smag[W][k][0];
      dq[0][k]   = '0;
    end
  end

  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    nrm_div_cell #(.W(W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (dv[j]),
      .len_i   (dlen[j]),
      .rem_i   (drem[j]),
      .nb_i    (dnb[j]),
      .q_i     (dq[j]),
      .neg_i   (dneg[j]),
      .valid_o (dv[j+1]),
      .len_o   (dlen[j+1]),
      .rem_o   (drem[j+1]),
      .nb_o    (dnb[j+1]),
      .q_o     (dq[j+1]),
      .neg_o   (dneg[j+1])
    );
  end

  always_comb begin
    uq = '0;
    for (int k = 0; k < LANES; k++) begin
      uq          = (dlen[QUOT_W] == '0) ? '0 : {1'b0, dq[QUOT_W][k]};
      unit_nxt[k] = dneg[QUOT_W][k] ? (~uq + 1'b1) : uq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len_out_r  <= DATA_W'(dlen[QUOT_W]);
      unit_out_r <= unit_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.vec_length = len_out_r;
  assign out_chan.unit_x     = unit_out_r[0];
  assign out_chan.unit_y     = unit_out_r[1];
  assign out_chan.unit_z     = unit_out_r[2];

  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (len_out_r == '0) |->
      (unit_out_r[0] == '0) && (unit_out_r[1] == '0) && (unit_out_r[2] == '0))
    else $error("zero length with nonzero unit vector");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ($signed(unit_out_r[0]) <= 32'sd1073741824) &&
      ($signed(unit_out_r[0]) >= -32'sd1073741824) &&
      ($signed(unit_out_r[1]) <= 32'sd1073741824) &&
      ($signed(unit_out_r[1]) >= -32'sd1073741824) &&
      ($signed(unit_out_r[2]) <= 32'sd1073741824) &&
      ($signed(unit_out_r[2]) >= -32'sd1073741824))
    else $error("unit component beyond one");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(dv[QUOT_W]))
    else $error("pipe advanced while result stalled");
endmodule

@@ sim/nrm_tb_if.sv @@
`timescale 1ns / 100ps
// Testbench types for request vectors and expected results.
package nrm_tb_pkg;
  import nrm_pkg::*;
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } vec_t;
  typedef struct packed {
    logic        [DATA_W-1:0] len;
    logic signed [DATA_W-1:0] ux;
    logic signed [DATA_W-1:0] uy;
    logic signed [DATA_W-1:0] uz;
  } norm_t;
endpackage

@@ sim/vector_normalize_core_tb.sv @@
`timescale 1ns / 100ps
// Testbench for vector_normalize_core: directed and random vectors, scoreboard check.
module vector_normalize_core_tb;
  import nrm_pkg::*;
  import nrm_tb_pkg::*;

  localparam int CW      = 32;
  localparam int LATENCY = CW + 35;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  nrm_in_if  in_chan ();
  nrm_out_if out_chan ();

  vector_normalize_core #(.COMPONENT_WIDTH(CW)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  norm_t expected_norms[$];
  int    error_count = 0;
  int    hold_off = 0;
  int    gap_max = 3;
  bit    stall_en = 1'b1;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.vec_x = '0;
    in_chan.vec_y = '0;
    in_chan.vec_z = '0;
    out_chan.ready = 1'b0;
  end

  function automatic logic [63:0] comp_mag(logic [DATA_W-1:0] raw);
    logic [CW-1:0] v;
    v = raw[CW-1:0];
    return v[CW-1] ? (64'd1 << CW) - {32'd0, v} : {32'd0, v};
  endfunction

  function automatic bit comp_mag_sign(int i, vec_t v);
    logic [DATA_W-1:0] f;
    f = (i == 0) ? v.x : (i == 1) ? v.y : v.z;
    return f[CW-1];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic norm_t normalize(vec_t v);
    logic [63:0] mag[3];
    logic [63:0] sum, len, q;
    logic [31:0] u[3];
    norm_t r;
    mag[0] = comp_mag(v.x);
    mag[1] = comp_mag(v.y);
    mag[2] = comp_mag(v.z);
    sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (len != 0) ? (mag[i] << FRAC_W) / len : 64'd0;
      u[i] = comp_mag_sign(i, v) ? 32'(64'd0 - q) : q[31:0];
    end
    r.len = len[31:0];
    r.ux = u[0];
    r.uy = u[1];
    r.uz = u[2];
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
    error_count++;
  endtask

  // send one request, sometimes with a random gap before it
  task automatic send_vector(vec_t v);
    int gap;
    gap = (gap_max == 0 || $urandom_range(0, 7) < 5) ? 0 : $urandom_range(1, gap_max);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.vec_x <= v.x;
    in_chan.vec_y <= v.y;
    in_chan.vec_z <= v.z;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_norms.push_back(normalize(v));
  endtask

  task automatic idle_sender();
    in_chan.valid <= 1'b0;
  endtask

  // receiver: stall pattern, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_chan.ready <= 1'b0;
    end else if (!stall_en) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    norm_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_norms.size() == 0) begin
        $display("unexpected result at %0t", $time);
        error_count++;
      end else begin
        want = expected_norms.pop_front();
        if (out_chan.vec_length !== want.len) report("vec_length", out_chan.vec_length, want.len);
        if (out_chan.unit_x !== want.ux) report("unit_x", out_chan.unit_x, want.ux);
        if (out_chan.unit_y !== want.uy) report("unit_y", out_chan.unit_y, want.uy);
        if (out_chan.unit_z !== want.uz) report("unit_z", out_chan.unit_z, want.uz);
      end
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      1: return 32'($signed($urandom_range(0, 512)) - 256);
      2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] vals[8];
    vec_t v;
    vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
             32'h0001_0000, 32'hffff_0000, 32'h0003_0000};
    send_vector('{x: 0, y: 0, z: 0});
    for (int i = 1; i < 8; i++) begin
      send_vector('{x: vals[i], y: 0, z: 0});
      send_vector('{x: 0, y: vals[i], z: 0});
      send_vector('{x: 0, y: 0, z: vals[i]});
    end
    send_vector('{x: 32'h8000_0000, y: 32'h8000_0000, z: 32'h8000_0000});
    send_vector('{x: 32'h7fff_ffff, y: 32'h8000_0000, z: 32'h7fff_ffff});
    v.x = 32'h0003_0000; v.y = 32'hfffc_0000; v.z = 32'h0;
    send_vector(v);
    idle_sender();
  endtask

  task automatic test_random(int count);
    vec_t v;
    for (int i = 0; i < count; i++) begin
      v.x = rand_comp();
      v.y = rand_comp();
      v.z = rand_comp();
      if (i % 200 == 100) gap_max = (gap_max == 0) ? 6 : 0;
      send_vector(v);
    end
    idle_sender();
  endtask

  // hold the receiver off long enough to fill the pipe and stall input
  task automatic test_backpressure();
    vec_t v;
    hold_off = 3 * LATENCY;
    for (int i = 0; i < 2 * LATENCY; i++) begin
      v.x = $urandom; v.y = $urandom; v.z = $urandom;
      send_vector(v);
    end
    idle_sender();
  endtask

  task automatic test_full_rate(int count);
    vec_t v;
    stall_en = 1'b0;
    gap_max = 0;
    for (int i = 0; i < count; i++) begin
      v.x = $urandom; v.y = rand_comp(); v.z = $urandom;
      send_vector(v);
    end
    idle_sender();
    stall_en = 1'b1;
    gap_max = 4;
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_backpressure();
    test_full_rate(150);
    test_random(150);
    waited = 0;
    while (expected_norms.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && expected_norms.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
